// ===== design/safety_fault_monitor_defines.svh =====
// Assertion macros used by the safety fault monitor checker.
// Depends on nothing; include with the bare file name.
`ifndef SAFETY_FAULT_MONITOR_DEFINES_SVH
`define SAFETY_FAULT_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("safety fault monitor check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("safety fault monitor check failed");

`endif

// ===== design/sfm_pkg.sv =====
// Types, constants and helper functions of the safety fault monitor.
// Used by the top level, the log engine and the checker; depends on nothing.
`default_nettype none

package sfm_pkg;

  localparam int LOG_DEPTH = 32;
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LOG_CW    = $clog2(LOG_DEPTH + 1);

  localparam int NUM_CHAN  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [2:0] OP_SAMPLE   = 3'd0;
  localparam logic [2:0] OP_REPORT   = 3'd1;
  localparam logic [2:0] OP_BUTTON   = 3'd2;
  localparam logic [2:0] OP_RECOVER  = 3'd3;
  localparam logic [2:0] OP_READ_LOG = 3'd4;

  localparam logic [2:0] LVL_NORMAL    = 3'd0;
  localparam logic [2:0] LVL_WARNING   = 3'd1;
  localparam logic [2:0] LVL_EMERGENCY = 3'd3;
  localparam logic [2:0] LVL_CRITICAL  = 3'd4;

  localparam logic [5:0] CODE_ESTOP = 6'd15;

  localparam logic [2:0] ACT_NONE = 3'd0;

  localparam logic [31:0] LIMIT_RESET [NUM_CHAN] = '{
    32'd52428850, 32'd55705650, 32'd58982450, 32'd98304050,
    32'd78643250, 32'd62259300, 32'd62259300
  };
  localparam logic [5:0] HIGH_CODE [NUM_CHAN] = '{
    6'd1, 6'd2, 6'd3, 6'd7, 6'd8, 6'd11, 6'd12
  };
  localparam logic [5:0] LOW_CODE [NUM_CHAN] = '{
    6'd4, 6'd5, 6'd6, 6'd9, 6'd10, 6'd13, 6'd14
  };
  localparam logic [2:0] HIGH_LEVEL [NUM_CHAN] = '{
    3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2
  };

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic signed [15:0] sample_value;
    logic        sensor_faulted;
    logic [5:0]  report_code;
    logic [2:0]  report_level;
    logic        button_pressed;
    logic [4:0]  log_index;
    logic [31:0] now_tick;
  } sfm_in_t;

  typedef struct packed {
    logic [2:0]  severity;
    logic        estop_latched;
    logic [5:0]  last_fault;
    logic [31:0] total_faults;
    logic        shutdown_active;
    logic [2:0]  emergency_action;
    logic        recovery_refused;
    logic        entry_valid;
    logic [5:0]  entry_code;
    logic [2:0]  entry_level;
    logic [15:0] entry_count;
    logic [31:0] entry_time;
  } sfm_out_t;

  typedef struct packed {
    logic [5:0]  code;
    logic [2:0]  level;
    logic [15:0] count;
    logic [31:0] time_tick;
  } log_entry_t;

  // Request from the control unit to the log engine.
  typedef struct packed {
    logic        valid;
    logic        is_read;
    logic [5:0]  code;
    logic [2:0]  level;
    logic [31:0] tick;
    logic [4:0]  index;
  } log_req_t;

  typedef struct packed {
    logic       done;
    logic       entry_valid;
    log_entry_t entry;
  } log_resp_t;

  // Heater-off or pump-stop request of an emergency-level fault.
  function automatic logic [2:0] fault_action(logic [5:0] code, logic [2:0] level);
    logic [2:0] act;
    act = ACT_NONE;
    if (level == LVL_EMERGENCY) begin
      if (code inside {[6'd1:6'd3]}) begin
        act = code[2:0];
      end else if (code inside {6'd7, 6'd8}) begin
        act = 3'(code - 6'd3);
      end
    end
    return act;
  endfunction

endpackage

`default_nettype wire

// ===== design/safety_fault_monitor.sv =====
// Safety fault monitor: one beat in, one beat out, items handled one at a time.
// Status-only items go through decode and output; log reads also wait on the log
// engine, and each logged fault passes through the fault and wait states while the
// log is searched, at most two faults per item. A new beat is taken once back in idle.
// The log search reads one entry per cycle from the log RAM; that sets the rate.
// Reset clears status, limits to defaults and the log fill count; no clear pass.
`default_nettype none

module safety_fault_monitor
  import sfm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sfm_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sfm_out_t                  out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FAULT  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]  state_q, state_d;
  sfm_in_t     item_q;
  logic [31:0] limits_q [NUM_CHAN];

  logic [2:0]  level_q;
  logic        estop_q;
  logic        shutdown_q;
  logic [5:0]  last_code_q;
  logic [31:0] total_q;
  logic [2:0]  act_q;
  logic        refused_q;
  logic        ent_valid_q;
  log_entry_t  ent_q;

  logic [5:0]  cur_code_q;
  logic [2:0]  cur_lvl_q;
  logic        pend_q;
  logic [5:0]  pend_code_q;
  logic [2:0]  pend_lvl_q;

  logic        out_valid_q;
  sfm_out_t    out_q;

  logic        chan_ok;
  logic        over_hi;
  logic        under_lo;
  logic        report_ok;
  logic        estop_new;
  logic        has_fault;
  logic [2:0]  cur_act;
  logic        out_free;
  log_req_t    req;
  log_resp_t   resp;

  assign chan_ok   = (item_q.channel < 3'(NUM_CHAN)) && !item_q.sensor_faulted;
  assign over_hi   = item_q.sample_value > $signed(limits_q[item_q.channel][31:16]);
  assign under_lo  = item_q.sample_value < $signed(limits_q[item_q.channel][15:0]);
  assign report_ok = item_q.report_level inside {[3'd1:3'd4]};
  assign estop_new = item_q.button_pressed && !estop_q;
  assign cur_act   = fault_action(cur_code_q, cur_lvl_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    has_fault = 1'b0;
    case (item_q.opcode)
      OP_SAMPLE: has_fault = chan_ok && (over_hi || under_lo);
      OP_REPORT: has_fault = report_ok;
      OP_BUTTON: has_fault = estop_new;
      default:   has_fault = 1'b0;
    endcase
  end

  always_comb begin
    req         = '0;
    req.code    = cur_code_q;
    req.level   = cur_lvl_q;
    req.tick    = item_q.now_tick;
    req.index   = item_q.log_index;
    req.is_read = state_q == S_DECODE;
    req.valid   = (state_q == S_FAULT) ||
                  (state_q == S_DECODE && item_q.opcode == OP_READ_LOG);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (item_q.opcode == OP_READ_LOG) begin
          state_d = S_WAIT;
        end else if (has_fault) begin
          state_d = S_FAULT;
        end else begin
          state_d = S_OUT;
        end
      end
      S_FAULT: state_d = S_WAIT;
      S_WAIT: begin
        if (resp.done) begin
          state_d = pend_q ? S_FAULT : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= LVL_NORMAL;
      estop_q     <= 1'b0;
      shutdown_q  <= 1'b0;
      last_code_q <= '0;
      total_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        limits_q[i] <= LIMIT_RESET[i];
      end
    end else begin
      state_q <= state_d;
      for (int i = 0; i < NUM_CHAN; i++) begin
        if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(i)) begin
          limits_q[i] <= cfg_data_i;
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_DECODE: begin
          // Both limits crossed: the high fault goes first, the low one waits.
          pend_q <= (item_q.opcode == OP_SAMPLE) && chan_ok && over_hi && under_lo;
          if (item_q.opcode == OP_BUTTON && estop_new) begin
            estop_q    <= 1'b1;
            shutdown_q <= 1'b1;
          end
          if (item_q.opcode == OP_RECOVER && !item_q.button_pressed) begin
            estop_q     <= 1'b0;
            shutdown_q  <= 1'b0;
            level_q     <= LVL_NORMAL;
            last_code_q <= '0;
          end
        end
        S_FAULT: begin
          last_code_q <= cur_code_q;
          total_q     <= total_q + 32'd1;
          if (cur_lvl_q > level_q) begin
            level_q <= cur_lvl_q;
          end
          if (cur_lvl_q == LVL_CRITICAL) begin
            shutdown_q <= 1'b1;
          end
        end
        S_WAIT: begin
          if (resp.done) begin
            pend_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_DECODE: begin
        act_q       <= ACT_NONE;
        refused_q   <= (item_q.opcode == OP_RECOVER) && item_q.button_pressed;
        ent_valid_q <= 1'b0;
        ent_q       <= '0;
        pend_code_q <= LOW_CODE[item_q.channel];
        pend_lvl_q  <= LVL_WARNING;
        case (item_q.opcode)
          OP_SAMPLE: begin
            cur_code_q <= over_hi ? HIGH_CODE[item_q.channel] : LOW_CODE[item_q.channel];
            cur_lvl_q  <= over_hi ? HIGH_LEVEL[item_q.channel] : LVL_WARNING;
          end
          OP_REPORT: begin
            cur_code_q <= item_q.report_code;
            cur_lvl_q  <= item_q.report_level;
          end
          default: begin
            cur_code_q <= CODE_ESTOP;
            cur_lvl_q  <= LVL_CRITICAL;
          end
        endcase
      end
      S_FAULT: begin
        if (cur_act != ACT_NONE) begin
          act_q <= cur_act;
        end
      end
      S_WAIT: begin
        if (resp.done) begin
          cur_code_q <= pend_code_q;
          cur_lvl_q  <= pend_lvl_q;
          if (item_q.opcode == OP_READ_LOG) begin
            ent_valid_q <= resp.entry_valid;
            ent_q       <= resp.entry;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_q <= '{
            severity:         level_q,
            estop_latched:    estop_q,
            last_fault:       last_code_q,
            total_faults:     total_q,
            shutdown_active:  shutdown_q,
            emergency_action: act_q,
            recovery_refused: refused_q,
            entry_valid:      ent_valid_q,
            entry_code:       ent_q.code,
            entry_level:      ent_q.level,
            entry_count:      ent_q.count,
            entry_time:       ent_q.time_tick
          };
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sfm_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .resp_o (resp)
  );

endmodule

`default_nettype wire

// ===== design/sfm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; the contents have no reset.
`default_nettype none

module sfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/sfm_log.sv =====
// Fault log engine: deduplicating search, update and append, and entry reads.
// Depends on sfm_pkg and sfm_ram.
`default_nettype none

module sfm_log
  import sfm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire log_req_t  req_i,
  output log_resp_t      resp_o
);

  localparam logic [1:0] E_IDLE   = 2'd0;
  localparam logic [1:0] E_SCAN   = 2'd1;
  localparam logic [1:0] E_APPEND = 2'd2;
  localparam logic [1:0] E_RDWAIT = 2'd3;

  localparam int IDXW = (LOG_CW > 5) ? LOG_CW : 5;

  logic [1:0]        state_q, state_d;
  logic [LOG_CW-1:0] used_q;
  logic [LOG_CW-1:0] cmp_idx_q;
  logic [LOG_CW-1:0] cmp_next;
  logic [5:0]        code_q;
  logic [2:0]        level_q;
  logic [31:0]       tick_q;
  logic              done_q, done_d;
  logic              ent_valid_q;
  log_entry_t        ent_q;

  logic              ram_we;
  logic [LOG_AW-1:0] ram_waddr;
  log_entry_t        ram_wdata;
  logic              ram_re;
  logic [LOG_AW-1:0] ram_raddr;
  log_entry_t        ram_rdata;

  logic [IDXW-1:0]   rd_idx;
  logic              rd_ok;
  logic              hit;

  assign cmp_next = cmp_idx_q + LOG_CW'(1);
  assign rd_idx   = IDXW'(req_i.index);
  assign rd_ok    = rd_idx < IDXW'(used_q);
  assign hit      = ram_rdata.code == code_q;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cmp_idx_q[LOG_AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cmp_next[LOG_AW-1:0];
    case (state_q)
      E_IDLE: begin
        if (req_i.valid) begin
          if (req_i.is_read) begin
            if (rd_ok) begin
              ram_re    = 1'b1;
              ram_raddr = rd_idx[LOG_AW-1:0];
              state_d   = E_RDWAIT;
            end else begin
              done_d = 1'b1;
            end
          end else if (used_q == '0) begin
            state_d = E_APPEND;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_d   = E_SCAN;
          end
        end
      end
      E_SCAN: begin
        // The entry read last cycle is compared while the next one is fetched.
        if (hit) begin
          ram_we          = 1'b1;
          ram_wdata.count = ram_rdata.count + 16'd1;
          ram_wdata.time_tick = tick_q;
          if (level_q > ram_rdata.level) begin
            ram_wdata.level = level_q;
          end
          done_d  = 1'b1;
          state_d = E_IDLE;
        end else if (cmp_next == used_q) begin
          state_d = E_APPEND;
        end else begin
          ram_re = 1'b1;
        end
      end
      E_APPEND: begin
        ram_waddr = used_q[LOG_AW-1:0];
        ram_wdata = '{code: code_q, level: level_q, count: 16'd1, time_tick: tick_q};
        ram_we    = used_q < LOG_CW'(LOG_DEPTH);
        done_d    = 1'b1;
        state_d   = E_IDLE;
      end
      E_RDWAIT: begin
        done_d  = 1'b1;
        state_d = E_IDLE;
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == E_APPEND && used_q < LOG_CW'(LOG_DEPTH)) begin
        used_q <= used_q + LOG_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && req_i.valid) begin
      code_q    <= req_i.code;
      level_q   <= req_i.level;
      tick_q    <= req_i.tick;
      cmp_idx_q <= '0;
      if (req_i.is_read && !rd_ok) begin
        ent_valid_q <= 1'b0;
        ent_q       <= '0;
      end
    end else if (state_q == E_SCAN) begin
      cmp_idx_q <= cmp_next;
    end else if (state_q == E_RDWAIT) begin
      ent_valid_q <= 1'b1;
      ent_q       <= ram_rdata;
    end
  end

  assign resp_o = '{done: done_q, entry_valid: ent_valid_q, entry: ent_q};

  sfm_ram #(
    .WIDTH ($bits(log_entry_t)),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== design/sfm_checker.sv =====
// Port-level checks of the safety fault monitor, bound to the top level.
// Depends on sfm_pkg and safety_fault_monitor_defines.svh.
`default_nettype none
`include "safety_fault_monitor_defines.svh"

module sfm_checker
  import sfm_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire sfm_out_t out_data_o
);

  `SFM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Shutdown is only ever latched together with the critical level.
  `SFM_ASSERT_IMPL(a_shutdown_critical, clk_i, rst_ni, out_valid_o && out_data_o.shutdown_active, out_data_o.severity == LVL_CRITICAL)

  `SFM_ASSERT_IMPL(a_estop_shutdown, clk_i, rst_ni, out_valid_o && out_data_o.estop_latched, out_data_o.shutdown_active)

  // A beat without a valid log entry carries an all-zero entry.
  `SFM_ASSERT_IMPL(a_entry_zero, clk_i, rst_ni, out_valid_o && !out_data_o.entry_valid, out_data_o.entry_code == 6'd0 && out_data_o.entry_level == 3'd0 && out_data_o.entry_count == 16'd0 && out_data_o.entry_time == 32'd0)

endmodule

bind safety_fault_monitor sfm_checker u_sfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
